// ===== src/ple_pkg.sv =====
package ple_pkg;

  localparam int DEPTH        = 32;
  localparam int RESULT_LIMIT = 32;

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam int IDX_W    = $clog2(DEPTH);
  localparam int LEN_W    = $clog2(DEPTH + 1);
  // wide enough to compare a position against length + 1 at any depth
  localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam int DUMP_MAX = (DEPTH < RESULT_LIMIT) ? DEPTH : RESULT_LIMIT;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_DUMP,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    WH_FRONT,
    WH_BACK,
    WH_POS
  } where_e;

  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } back_state_e;

  typedef struct packed {
    op_e                     op;
    where_e                  where;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } work_t;

  typedef struct packed {
    status_e                 status;
    logic [COUNT_W-1:0]      count;
    logic signed [VAL_W-1:0] elem_value;
    logic                    elem_valid;
    logic                    last;
  } res_t;

endpackage

// ===== src/ple_front.sv =====
module ple_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [ple_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [ple_pkg::VAL_W-1:0] value_i,
  input  logic [ple_pkg::POS_W-1:0]        position_i,
  output logic                             full_o,
  output ple_pkg::work_t                   work_o,
  output logic                             work_valid_o,
  input  logic                             work_ready_i
);
  import ple_pkg::*;

  logic  vld_q, vld_d;
  work_t work_q, work_d;
  logic  accept;

  assign full_o = vld_q & ~work_ready_i;
  assign accept = push_i & ~full_o;
  assign vld_d  = accept | (vld_q & ~work_ready_i);

  // classify the command into an operation and where it acts
  always_comb begin
    work_d          = work_q;
    if (accept) begin
      work_d.value    = value_i;
      work_d.position = position_i;
      work_d.where    = WH_FRONT;
      unique case (cmd_i)
        CMD_INS_FRONT: begin
          work_d.op = OP_INSERT;
        end
        CMD_INS_BACK: begin
          work_d.op    = OP_INSERT;
          work_d.where = WH_BACK;
        end
        CMD_INS_AT: begin
          work_d.op    = OP_INSERT;
          work_d.where = WH_POS;
        end
        CMD_DEL_FRONT: begin
          work_d.op = OP_DELETE;
        end
        CMD_DEL_BACK: begin
          work_d.op    = OP_DELETE;
          work_d.where = WH_BACK;
        end
        CMD_DEL_AT: begin
          work_d.op    = OP_DELETE;
          work_d.where = WH_POS;
        end
        CMD_DUMP: begin
          work_d.op = OP_DUMP;
        end
        default: begin
          work_d.op = OP_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign work_o       = work_q;
  assign work_valid_o = vld_q;

endmodule

// ===== src/ple_cmd_fifo.sv =====
module ple_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ple_pkg::work_t in_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output ple_pkg::work_t out_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);
  import ple_pkg::*;

  work_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign wr          = in_valid_i & in_ready_o;
  assign rd          = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= in_i;
    end
  end

  assign out_o = mem_q[rd_ptr_q];

endmodule

// ===== src/ple_back.sv =====
module ple_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ple_pkg::work_t                    work_i,
  input  logic                              work_valid_i,
  output logic                              work_ready_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [ple_pkg::STATUS_W-1:0]      status_o,
  output logic [ple_pkg::COUNT_W-1:0]       count_o,
  output logic signed [ple_pkg::VAL_W-1:0]  elem_value_o,
  output logic                              elem_valid_o,
  output logic                              last_o
);
  import ple_pkg::*;

  logic signed [VAL_W-1:0] cells_q [DEPTH];
  logic [LEN_W-1:0]        len_q, len_d;
  back_state_e             state_q, state_d;
  logic [IDX_W-1:0]        k_q, k_d;

  res_t       oq_q [2];
  logic       owr_ptr_q, ord_ptr_q;
  logic [1:0] ocnt_q;
  logic       out_room, owr, ord;
  res_t       ores;

  logic             exec, do_ins, do_del;
  logic [IDX_W-1:0] idx;
  status_e          st;
  logic [CMP_W-1:0] pos_c, len_c, n_c;
  logic [IDX_W-1:0] last_k;

  assign out_room = (ocnt_q != 2'd2);
  assign pos_c    = CMP_W'(work_i.position);
  assign len_c    = CMP_W'(len_q);
  assign n_c      = (len_c > CMP_W'(DUMP_MAX)) ? CMP_W'(DUMP_MAX) : len_c;
  assign last_k   = IDX_W'(n_c - CMP_W'(1));
  assign exec     = (state_q == BK_IDLE) & work_valid_i & out_room;
  assign work_ready_o = exec;

  always_comb begin
    st      = ST_OK;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    idx     = '0;
    len_d   = len_q;
    state_d = state_q;
    k_d     = k_q;
    owr     = 1'b0;
    ores    = '0;

    unique case (state_q)
      BK_IDLE: begin
        if (exec) begin
          unique case (work_i.where)
            WH_FRONT: idx = '0;
            WH_BACK:  idx = (work_i.op == OP_INSERT) ? IDX_W'(len_q)
                                                     : IDX_W'(len_q - LEN_W'(1));
            default:  idx = IDX_W'(work_i.position - POS_W'(1));
          endcase
          case (work_i.op)
            OP_INSERT: begin
              if (work_i.where == WH_POS &&
                  (pos_c == '0 || pos_c > len_c + CMP_W'(1))) begin
                st = ST_BADPOS;
              end else if (len_c >= CMP_W'(DEPTH)) begin
                st = ST_FULL;
              end else begin
                do_ins = 1'b1;
                len_d  = len_q + LEN_W'(1);
              end
            end
            OP_DELETE: begin
              if (len_q == '0) begin
                st = ST_EMPTY;
              end else if (work_i.where == WH_POS &&
                           (pos_c == '0 || pos_c > len_c)) begin
                st = ST_BADPOS;
              end else begin
                do_del = 1'b1;
                len_d  = len_q - LEN_W'(1);
              end
            end
            default: ;
          endcase
          if (work_i.op == OP_DUMP && n_c != '0) begin
            state_d = BK_DUMP;
            k_d     = '0;
          end else begin
            owr          = 1'b1;
            ores.status  = st;
            ores.count   = COUNT_W'(len_d);
            ores.last    = 1'b1;
          end
        end
      end
      BK_DUMP: begin
        if (out_room) begin
          owr             = 1'b1;
          ores.status     = ST_OK;
          ores.count      = COUNT_W'(len_q);
          ores.elem_value = cells_q[k_q];
          ores.elem_valid = 1'b1;
          ores.last       = (k_q == last_k);
          k_d             = k_q + IDX_W'(1);
          if (k_q == last_k) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // row of cells: shift up behind an insert, shift down over a delete
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        if (idx == IDX_W'(g)) begin
          cells_q[g] <= work_i.value;
        end else if (idx < IDX_W'(g)) begin
          if (g > 0) begin
            cells_q[g] <= cells_q[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (do_del && idx <= IDX_W'(g)) begin
        if (g < DEPTH - 1) begin
          cells_q[g] <= cells_q[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      len_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      k_q     <= k_d;
    end
  end

  // result queue, parts the list from the consumer
  assign ord     = pop_i & ~empty_o;
  assign empty_o = (ocnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_ptr_q <= 1'b0;
      ord_ptr_q <= 1'b0;
      ocnt_q    <= 2'd0;
    end else begin
      if (owr) owr_ptr_q <= ~owr_ptr_q;
      if (ord) ord_ptr_q <= ~ord_ptr_q;
      ocnt_q <= ocnt_q + 2'(owr) - 2'(ord);
    end
  end

  always_ff @(posedge clk_i) begin
    if (owr) begin
      oq_q[owr_ptr_q] <= ores;
    end
  end

  assign status_o     = oq_q[ord_ptr_q].status;
  assign count_o      = oq_q[ord_ptr_q].count;
  assign elem_value_o = oq_q[ord_ptr_q].elem_value;
  assign elem_valid_o = oq_q[ord_ptr_q].elem_valid;
  assign last_o       = oq_q[ord_ptr_q].last;

endmodule

// ===== src/positional_list_engine.sv =====
// Ordered list of up to 32 signed 32-bit words, held in a row of cells that
// all shift at once. An insert or delete at the front, the back or a 1-based
// position is done in the list unit as it is taken, so such commands flow
// at one word per cycle while no dump runs and the result queue has room;
// the result word passes the front register and both queues. A dump enters
// a dump state, then reads one element at a time (at most 32) through the
// single read of the cell row; it gives a run of element words with last
// set on the final one. Every result carries a status (ok, bad position,
// full, empty) and the element count after the command. A two-entry command
// queue and a two-entry result queue let both sides stall on their own.
module positional_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [ple_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [ple_pkg::VAL_W-1:0]  value_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [ple_pkg::STATUS_W-1:0]      status_o,
  output logic [ple_pkg::COUNT_W-1:0]       count_o,
  output logic signed [ple_pkg::VAL_W-1:0]  elem_value_o,
  output logic                              elem_valid_o,
  output logic                              last_o
);
  import ple_pkg::*;

  work_t fr_work, bk_work;
  logic  fr_valid, fr_ready;
  logic  bk_valid, bk_ready;

  ple_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .full_o       (full),
    .work_o       (fr_work),
    .work_valid_o (fr_valid),
    .work_ready_i (fr_ready)
  );

  ple_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (fr_work),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .out_o       (bk_work),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready)
  );

  ple_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (bk_work),
    .work_valid_i (bk_valid),
    .work_ready_o (bk_ready),
    .empty_o      (empty),
    .pop_i        (pop),
    .status_o     (status_o),
    .count_o      (count_o),
    .elem_value_o (elem_value_o),
    .elem_valid_o (elem_valid_o),
    .last_o       (last_o)
  );

endmodule
